// File: sv/bsc_pkg.sv
// Shared constants, types and helpers for the bounding sphere block.
package bsc_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int COORD_W      = 32;
	localparam int ADDR_W       = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int SQ_W         = 64;
	localparam int ROOT_W       = 32;
	localparam int RADIUS_W     = 33;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vertex_t;

	// keep the low COORD_W bits of a coordinate, sign-extended to 32
	function automatic logic signed [31:0] sext_coord(input logic [31:0] raw);
		logic signed [COORD_W-1:0] v;
		v = raw[COORD_W-1:0];
		return 32'(v);
	endfunction

endpackage

// File: sv/bsc_store.sv
// Vertex store: one write port, one read port with registered read data.
module bsc_store (
	input  logic                       clk,
	input  logic                       we,
	input  logic [bsc_pkg::ADDR_W-1:0] waddr,
	input  bsc_pkg::vertex_t           wdata,
	input  logic                       re,
	input  logic [bsc_pkg::ADDR_W-1:0] raddr,
	output bsc_pkg::vertex_t           rdata
);

	bsc_pkg::vertex_t mem [bsc_pkg::MAX_VERTICES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/bsc_dist.sv
// Distance pipeline: squared distance of each read vertex to the center, running maximum.
module bsc_dist (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clear,
	input  logic                     rd_en,
	input  bsc_pkg::vertex_t         rdata,
	input  bsc_pkg::vertex_t         center,
	output logic [bsc_pkg::SQ_W-1:0] best,
	output logic                     busy
);

	logic                     v_s1, v_s2, v_s3, v_s4;
	logic [31:0]              mx_s2, my_s2, mz_s2;
	logic [bsc_pkg::SQ_W-1:0] sx_s3, sy_s3, sz_s3;
	logic [bsc_pkg::SQ_W-1:0] sum_s4;
	logic [bsc_pkg::SQ_W-1:0] best_q;
	logic signed [32:0]       dx, dy, dz;
	logic [32:0]              ax, ay, az;

	// |v - c| is at most 2^31 since c is the midpoint of the extent
	always_comb begin
		dx = 33'(rdata.x) - 33'(center.x);
		dy = 33'(rdata.y) - 33'(center.y);
		dz = 33'(rdata.z) - 33'(center.z);
		ax = dx[32] ? 33'(-dx) : 33'(dx);
		ay = dy[32] ? 33'(-dy) : 33'(dy);
		az = dz[32] ? 33'(-dz) : 33'(dz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		mx_s2  <= ax[31:0];
		my_s2  <= ay[31:0];
		mz_s2  <= az[31:0];
		sx_s3  <= 64'(mx_s2) * 64'(mx_s2);
		sy_s3  <= 64'(my_s2) * 64'(my_s2);
		sz_s3  <= 64'(mz_s2) * 64'(mz_s2);
		sum_s4 <= sx_s3 + sy_s3 + sz_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (clear) begin
			best_q <= '0;
		end else if (v_s4 && (sum_s4 > best_q)) begin
			best_q <= sum_s4;
		end
	end

	assign best = best_q;
	assign busy = v_s1 | v_s2 | v_s3 | v_s4;

endmodule

// File: sv/bsc_isqrt.sv
// Floor square root of a 64-bit value, one result bit per cycle.
module bsc_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [bsc_pkg::SQ_W-1:0]   radicand,
	output logic                       done,
	output logic [bsc_pkg::ROOT_W-1:0] root
);

	localparam int REM_W = bsc_pkg::ROOT_W + 4;
	localparam int ITER_W = $clog2(bsc_pkg::ROOT_W);

	logic                       run_q, done_q;
	logic [ITER_W-1:0]          cnt_q;
	logic [bsc_pkg::SQ_W-1:0]   x_q;
	logic [REM_W-1:0]           rem_q;
	logic [bsc_pkg::ROOT_W-1:0] root_q;
	logic [REM_W-1:0]           rem_sh, trial, rem_next;
	logic                       ge;

	always_comb begin
		rem_sh   = {rem_q[REM_W-3:0], x_q[bsc_pkg::SQ_W-1 -: 2]};
		trial    = {2'b00, root_q, 2'b01};
		ge       = rem_sh >= trial;
		rem_next = ge ? rem_sh - trial : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ITER_W'(bsc_pkg::ROOT_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			x_q    <= {x_q[bsc_pkg::SQ_W-3:0], 2'b00};
			rem_q  <= rem_next;
			root_q <= {root_q[bsc_pkg::ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: sv/bounding_sphere_compute.sv
// Bounding sphere of a vertex set: vertices stream in one per cycle (start while busy is
// low) and are written to a 1024-entry store while the per-axis extent is tracked. The item
// with last_vertex set ends the set; busy then stays high while the block computes the
// center, makes N reads through the single read port of the store, N being the stored
// vertex count, drains the distance pipeline and then runs the bit-serial square
// root. The result appears for one cycle with done high and cannot be held off; the next
// set may start in that same cycle. Vertices arriving once the store is full are dropped
// and reported through overflow.
module bounding_sphere_compute (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [31:0]           pos_x,
	input  logic signed [31:0]           pos_y,
	input  logic signed [31:0]           pos_z,
	input  logic                         last_vertex,
	output logic                         done,
	output logic signed [31:0]           center_x,
	output logic signed [31:0]           center_y,
	output logic signed [31:0]           center_z,
	output logic [bsc_pkg::RADIUS_W-1:0] radius,
	output logic                         overflow
);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_CENTER,
		ST_WALK,
		ST_DRAIN,
		ST_ROOT
	} state_t;

	state_t                     state_q;
	logic [bsc_pkg::CNT_W-1:0]  count_q, rd_idx_q;
	logic                       dropped_q, done_q;
	bsc_pkg::vertex_t           min_q, max_q, center_q, vin;
	logic                       accept, wr_en, rd_en, walk_end, sq_go;
	logic signed [32:0]         sum_x, sum_y, sum_z;
	bsc_pkg::vertex_t           rdata;
	logic [bsc_pkg::SQ_W-1:0]   best;
	logic                       pipe_busy, sq_done;
	logic [bsc_pkg::ROOT_W-1:0] root;

	always_comb begin
		vin.x    = bsc_pkg::sext_coord(pos_x);
		vin.y    = bsc_pkg::sext_coord(pos_y);
		vin.z    = bsc_pkg::sext_coord(pos_z);
		accept   = start && (state_q == ST_LOAD);
		wr_en    = accept && (count_q < bsc_pkg::CNT_W'(bsc_pkg::MAX_VERTICES));
		rd_en    = (state_q == ST_WALK) && (rd_idx_q < count_q);
		walk_end = ({1'b0, rd_idx_q} + 1'b1) >= {1'b0, count_q};
		sq_go    = (state_q == ST_DRAIN) && !pipe_busy;
		// floor midpoint: 33-bit sum, arithmetic shift by one
		sum_x    = 33'(min_q.x) + 33'(max_q.x);
		sum_y    = 33'(min_q.y) + 33'(max_q.y);
		sum_z    = 33'(min_q.z) + 33'(max_q.z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			rd_idx_q  <= '0;
			dropped_q <= 1'b0;
			done_q    <= 1'b0;
			min_q     <= '0;
			max_q     <= '0;
			center_q  <= '0;
			center_x  <= '0;
			center_y  <= '0;
			center_z  <= '0;
			radius    <= '0;
			overflow  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (wr_en) begin
							count_q <= count_q + 1'b1;
							if (count_q == '0) begin
								min_q <= vin;
								max_q <= vin;
							end else begin
								if (vin.x < min_q.x) min_q.x <= vin.x;
								if (vin.y < min_q.y) min_q.y <= vin.y;
								if (vin.z < min_q.z) min_q.z <= vin.z;
								if (vin.x > max_q.x) max_q.x <= vin.x;
								if (vin.y > max_q.y) max_q.y <= vin.y;
								if (vin.z > max_q.z) max_q.z <= vin.z;
							end
						end else begin
							dropped_q <= 1'b1;
						end
						if (last_vertex) begin
							state_q <= ST_CENTER;
						end
					end
				end
				ST_CENTER: begin
					center_q.x <= sum_x[32:1];
					center_q.y <= sum_y[32:1];
					center_q.z <= sum_z[32:1];
					rd_idx_q   <= '0;
					state_q    <= ST_WALK;
				end
				ST_WALK: begin
					rd_idx_q <= rd_idx_q + 1'b1;
					if (walk_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (sq_go) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (sq_done) begin
						center_x  <= center_q.x;
						center_y  <= center_q.y;
						center_z  <= center_q.z;
						radius    <= bsc_pkg::RADIUS_W'(root);
						overflow  <= dropped_q;
						done_q    <= 1'b1;
						count_q   <= '0;
						dropped_q <= 1'b0;
						min_q     <= '0;
						max_q     <= '0;
						state_q   <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_LOAD);
	assign done = done_q;

	bsc_store u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[bsc_pkg::ADDR_W-1:0]),
		.wdata (vin),
		.re    (rd_en),
		.raddr (rd_idx_q[bsc_pkg::ADDR_W-1:0]),
		.rdata (rdata)
	);

	bsc_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (state_q == ST_CENTER),
		.rd_en  (rd_en),
		.rdata  (rdata),
		.center (center_q),
		.best   (best),
		.busy   (pipe_busy)
	);

	bsc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (sq_go),
		.radicand (best),
		.done     (sq_done),
		.root     (root)
	);

endmodule

// File: test/bounding_sphere_compute_checker.sv
`timescale 1ns / 1ps
// Checker for bounding_sphere_compute: mirrors the vertex store and extents, checks every sphere.
module bounding_sphere_compute_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic signed [31:0]           pos_x,
	input  logic signed [31:0]           pos_y,
	input  logic signed [31:0]           pos_z,
	input  logic                         last_vertex,
	input  logic                         done,
	input  logic signed [31:0]           center_x,
	input  logic signed [31:0]           center_y,
	input  logic signed [31:0]           center_z,
	input  logic [bsc_pkg::RADIUS_W-1:0] radius,
	input  logic                         overflow,
	output int                           fail_count,
	output int                           outstanding
);
	import bsc_pkg::*;

	typedef struct {
		logic signed [31:0]  cx;
		logic signed [31:0]  cy;
		logic signed [31:0]  cz;
		logic [RADIUS_W-1:0] rad;
		logic                ovf;
	} sphere_t;

	sphere_t            pending_spheres[$];
	sphere_t            want;
	logic signed [31:0] mem_x [MAX_VERTICES];
	logic signed [31:0] mem_y [MAX_VERTICES];
	logic signed [31:0] mem_z [MAX_VERTICES];
	logic signed [31:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
	int                 held;
	logic               lost;
	int                 mismatches;

	assign fail_count = mismatches;

	// low COORD_W bits, sign-extended
	function automatic logic signed [31:0] narrow_coord(input logic [31:0] raw);
		logic [31:0] t;
		t = raw << (32 - COORD_W);
		return $signed(t) >>> (32 - COORD_W);
	endfunction

	// floor of (a + b) / 2 from the 33-bit sum
	function automatic logic signed [31:0] mid_of(input logic signed [31:0] a, b);
		logic [32:0] s;
		s = {a[31], a} + {b[31], b};
		return s[32:1];
	endfunction

	function automatic logic [63:0] sq_gap(input logic signed [31:0] a, c);
		logic signed [33:0] d;
		logic [63:0]        m;
		d = {{2{a[31]}}, a} - {{2{c[31]}}, c};
		m = 64'(d[33] ? -d : d);
		return m * m;
	endfunction

	function automatic logic [RADIUS_W-1:0] floor_root(input logic [63:0] v);
		logic [63:0] acc, bitv, rem;
		acc  = '0;
		rem  = v;
		bitv = 64'd1 << 62;
		while (bitv > rem)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= acc + bitv) begin
				rem = rem - (acc + bitv);
				acc = (acc >> 1) + bitv;
			end else begin
				acc = acc >> 1;
			end
			bitv = bitv >> 2;
		end
		return acc[RADIUS_W-1:0];
	endfunction

	task automatic flag(input string what, input logic [63:0] exp_v, input logic [63:0] act_v);
		if (mismatches < 10)
			$display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, act_v);
		mismatches++;
	endtask

	task automatic clear_set();
		held = 0;
		lost = 1'b0;
		lo_x = '0; lo_y = '0; lo_z = '0;
		hi_x = '0; hi_y = '0; hi_z = '0;
	endtask

	// one accepted vertex item; a last item closes the set and queues its sphere
	task automatic absorb_vertex(input logic [31:0] rx, ry, rz, input logic last);
		logic signed [31:0] px, py, pz;
		logic [63:0]        best, d2;
		sphere_t            s;
		px = narrow_coord(rx);
		py = narrow_coord(ry);
		pz = narrow_coord(rz);
		if (held < MAX_VERTICES) begin
			if (held == 0) begin
				lo_x = px; hi_x = px;
				lo_y = py; hi_y = py;
				lo_z = pz; hi_z = pz;
			end else begin
				if (px < lo_x) lo_x = px;
				if (py < lo_y) lo_y = py;
				if (pz < lo_z) lo_z = pz;
				if (px > hi_x) hi_x = px;
				if (py > hi_y) hi_y = py;
				if (pz > hi_z) hi_z = pz;
			end
			mem_x[held] = px;
			mem_y[held] = py;
			mem_z[held] = pz;
			held++;
		end else begin
			lost = 1'b1;
		end
		if (last) begin
			s.cx = '0; s.cy = '0; s.cz = '0;
			best = '0;
			if (held != 0) begin
				s.cx = mid_of(lo_x, hi_x);
				s.cy = mid_of(lo_y, hi_y);
				s.cz = mid_of(lo_z, hi_z);
				for (int i = 0; i < held; i++) begin
					d2 = sq_gap(mem_x[i], s.cx) + sq_gap(mem_y[i], s.cy)
						+ sq_gap(mem_z[i], s.cz);
					if (d2 > best)
						best = d2;
				end
			end
			s.rad = floor_root(best);
			s.ovf = lost;
			pending_spheres = {pending_spheres, s};
			clear_set();
		end
	endtask

	initial mismatches = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_set();
			pending_spheres.delete();
			outstanding <= 0;
		end else begin
			if (done) begin
				if (pending_spheres.size() == 0) begin
					flag("unexpected result, radius", '0, radius);
				end else begin
					want = pending_spheres.pop_front();
					if (center_x !== want.cx) flag("center_x", want.cx, center_x);
					if (center_y !== want.cy) flag("center_y", want.cy, center_y);
					if (center_z !== want.cz) flag("center_z", want.cz, center_z);
					if (radius !== want.rad) flag("radius", want.rad, radius);
					if (overflow !== want.ovf) flag("overflow", want.ovf, overflow);
				end
			end
			if (start && !busy)
				absorb_vertex(pos_x, pos_y, pos_z, last_vertex);
			outstanding <= pending_spheres.size();
		end
	end

endmodule

// File: test/bounding_sphere_compute_tb.sv
`timescale 1ns / 1ps
// Top of the bounding_sphere_compute testbench: clock, reset, vertex stimulus and verdict.
module bounding_sphere_compute_tb;
	import bsc_pkg::*;

	localparam int VERTEX_BUDGET = 1950;
	localparam int FULL_SET_LEN  = MAX_VERTICES + 3;   // last three items dropped, last one closes

	localparam int SPREAD_FULL    = 0;
	localparam int SPREAD_CLUSTER = 1;
	localparam int SPREAD_EDGE    = 2;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  start       = 1'b0;
	logic signed [31:0]    pos_x       = '0;
	logic signed [31:0]    pos_y       = '0;
	logic signed [31:0]    pos_z       = '0;
	logic                  last_vertex = 1'b0;
	logic                  busy;
	logic                  done;
	logic signed [31:0]    center_x, center_y, center_z;
	logic [RADIUS_W-1:0]   radius;
	logic                  overflow;
	int                    fail_count;
	int                    outstanding;
	int                    sent = 0;

	always #6 clk = ~clk;

	bounding_sphere_compute uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .last_vertex(last_vertex),
		.done(done), .center_x(center_x), .center_y(center_y), .center_z(center_z),
		.radius(radius), .overflow(overflow)
	);

	bounding_sphere_compute_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .last_vertex(last_vertex),
		.done(done), .center_x(center_x), .center_y(center_y), .center_z(center_z),
		.radius(radius), .overflow(overflow),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	initial begin
		#15_000_000;
		$display("bounding_sphere_compute verification failed");
		$finish;
	end

	task automatic push_vertex(input logic [31:0] x, y, z, input logic last);
		start       <= 1'b1;
		pos_x       <= x;
		pos_y       <= y;
		pos_z       <= z;
		last_vertex <= last;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return;
		else if (r < 95)
			idle_cycles($urandom_range(1, 3));
		else
			idle_cycles($urandom_range(10, 40));
	endtask

	// hold off until every queued sphere has come out
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_coord(input int mode, input logic [31:0] base);
		case (mode)
			SPREAD_FULL:    return $urandom;
			SPREAD_CLUSTER: return base + 32'($urandom_range(0, 4095)) - 32'd2048;
			default: begin
				case ($urandom_range(0, 4))
					0:       return 32'h8000_0000;
					1:       return 32'h7fff_ffff;
					2:       return 32'h0000_0000;
					3:       return 32'hffff_ffff;
					default: return $urandom;
				endcase
			end
		endcase
	endfunction

	task automatic send_set(input int len, input int mode);
		logic [31:0] bx, by, bz;
		bx = $urandom;
		by = $urandom;
		bz = $urandom;
		for (int i = 0; i < len; i++) begin
			push_vertex(pick_coord(mode, bx), pick_coord(mode, by), pick_coord(mode, bz),
				i == len - 1);
			random_gap();
		end
	endtask

	initial begin
		int  len;
		int  guard;
		bit  full_done;
		full_done = 0;
		guard     = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-vertex sets
		push_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
		push_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 1'b1);
		// full extent on every axis: largest radius
		push_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
		push_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
		// odd negative sum, center must round toward minus infinity
		push_vertex(32'hffff_fffd, 32'hffff_fffd, 32'hffff_fffd, 1'b0);
		push_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
		// mixed extremes, back to back
		push_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
		push_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
		push_vertex(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
		push_vertex(32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 1'b0);
		push_vertex(32'h0001_0000, 32'hfffe_0000, 32'h0003_8000, 1'b1);
		drain();

		while (sent < VERTEX_BUDGET) begin
			if (!full_done && sent >= 500) begin
				// store fills up; trailing items are dropped, the dropped last one closes
				drain();
				send_set(FULL_SET_LEN, SPREAD_FULL);
				full_done = 1;
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
					: $urandom_range(1, 12);
				send_set(len, $urandom_range(SPREAD_FULL, SPREAD_EDGE));
			end
			if ($urandom_range(0, 7) == 0)
				drain();
		end

		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("bounding_sphere_compute verification clean");
		else
			$display("bounding_sphere_compute verification failed");
		$finish;
	end

endmodule
